// File: rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared definitions for the slew-limited PWM drive unit
// Field widths, register reset values, command and register codes, and
// sequencer states.
// ----------------------------------------------------------------------------
package msp_pkg;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int CHANNEL_W = 3;
  localparam int TARGET_W  = 17;
  localparam int DRIVE_W   = 16;
  localparam int MAG_W     = 15;
  localparam int WRAP_W    = 16;
  localparam int ACTIVE_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Channels reachable through the channel field
  localparam int CH_LIMIT         = 2 ** CHANNEL_W;
  localparam int MAX_CHANNELS_DEF = 8;

  // Q1.15 full scale
  localparam logic signed [DRIVE_W-1:0] FULL_SCALE     = 16'sd32767;
  localparam logic signed [DRIVE_W-1:0] NEG_FULL_SCALE = -16'sd32767;

  // Register reset values
  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd0;
  localparam logic [WRAP_W-1:0]   WRAP_RST   = 16'd4999;
  localparam logic [MAG_W-1:0]    STEP_RST   = 15'd1638;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_TARGET = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_SET_ENABLE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_BRIDGES = 2'd0,
    CFG_PWM_WRAP       = 2'd1,
    CFG_SLEW_STEP      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SLEW = 2'd1,
    ST_MUL  = 2'd2,
    ST_OUT  = 2'd3
  } state_e;

  // Sequencer control toward the datapath
  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic slew_en;
    logic mul_en;
  } ctrl_t;

endpackage

// File: rtl/msp_in_if.sv
// ----------------------------------------------------------------------------
// msp_in_if: command channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface msp_in_if;

  logic                                  valid;
  logic                                  ready;
  logic [msp_pkg::CMD_W-1:0]             cmd;
  logic [msp_pkg::CHANNEL_W-1:0]         channel;
  logic signed [msp_pkg::TARGET_W-1:0]   target_value;
  logic                                  enable_value;

  modport source (
    output valid, cmd, channel, target_value, enable_value,
    input  ready
  );

  modport sink (
    input  valid, cmd, channel, target_value, enable_value,
    output ready
  );

endinterface

// File: rtl/msp_out_if.sv
// ----------------------------------------------------------------------------
// msp_out_if: drive result channel
// Valid/ready channel carrying one per-channel drive transaction.
// ----------------------------------------------------------------------------
interface msp_out_if;

  logic                              valid;
  logic                              ready;
  logic [msp_pkg::CHANNEL_W-1:0]     out_channel;
  logic                              phase;
  logic [msp_pkg::WRAP_W-1:0]        duty_level;
  logic                              driver_off;
  logic                              last;

  modport source (
    output valid, out_channel, phase, duty_level, driver_off, last,
    input  ready
  );

  modport sink (
    input  valid, out_channel, phase, duty_level, driver_off, last,
    output ready
  );

endinterface

// File: rtl/msp_slew_unit.sv
// ----------------------------------------------------------------------------
// msp_slew_unit: shared slew step
// Moves one drive value toward its target by at most the slew step and
// returns the new value with its sign and magnitude.
// ----------------------------------------------------------------------------
module msp_slew_unit (
  input  logic signed [msp_pkg::DRIVE_W-1:0] cur_i,
  input  logic signed [msp_pkg::DRIVE_W-1:0] target_i,
  input  logic        [msp_pkg::MAG_W-1:0]   step_i,
  output logic signed [msp_pkg::DRIVE_W-1:0] cur_o,
  output logic        [msp_pkg::MAG_W-1:0]   mag_o,
  output logic                               neg_o
);
  import msp_pkg::*;

  logic signed [DRIVE_W:0] err;
  logic        [DRIVE_W:0] err_mag;
  logic signed [DRIVE_W:0] step_ext;
  logic signed [DRIVE_W:0] nxt;
  logic signed [DRIVE_W-1:0] neg_cur;

  // Error between target and current, exact in one extra bit
  assign err      = (DRIVE_W+1)'(target_i) - (DRIVE_W+1)'(cur_i);
  assign err_mag  = err[DRIVE_W] ? (DRIVE_W+1)'(-err) : (DRIVE_W+1)'(err);
  assign step_ext = signed'({2'b00, step_i});

  // Jump to target when close, else step toward it; hold on zero error
  always_comb begin
    if (err_mag < (DRIVE_W+1)'(step_i)) begin
      nxt = (DRIVE_W+1)'(target_i);
    end else if (err[DRIVE_W]) begin
      nxt = (DRIVE_W+1)'(cur_i) - step_ext;
    end else if (err != '0) begin
      nxt = (DRIVE_W+1)'(cur_i) + step_ext;
    end else begin
      nxt = (DRIVE_W+1)'(cur_i);
    end
  end

  assign cur_o   = nxt[DRIVE_W-1:0];
  assign neg_o   = cur_o[DRIVE_W-1];
  assign neg_cur = -cur_o;
  assign mag_o   = neg_o ? neg_cur[MAG_W-1:0] : cur_o[MAG_W-1:0];

endmodule

// File: rtl/msp_duty_mul.sv
// ----------------------------------------------------------------------------
// msp_duty_mul: duty level multiplier
// Registers (wrap * magnitude) >> 15 for one channel.
// ----------------------------------------------------------------------------
module msp_duty_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [msp_pkg::WRAP_W-1:0]    wrap_i,
  input  logic [msp_pkg::MAG_W-1:0]     mag_i,
  output logic [msp_pkg::WRAP_W-1:0]    duty_o
);
  import msp_pkg::*;

  localparam int PROD_W = WRAP_W + MAG_W;

  logic [PROD_W-1:0] prod;
  logic [WRAP_W-1:0] duty_q;

  assign prod = PROD_W'(wrap_i) * PROD_W'(mag_i);

  // Capture the scaled product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      duty_q <= prod[PROD_W-1:MAG_W];
    end
  end

  assign duty_o = duty_q;

endmodule

// File: rtl/multichannel_slew_limited_pwm_drive_unit.sv
// ----------------------------------------------------------------------------
// multichannel_slew_limited_pwm_drive_unit: slew-limited H-bridge PWM drive
// Set-target and set-enable transactions are accepted while idle. A tick walks
// channels 0..n-1 through one shared slew unit and multiplier: each channel
// passes the slew, multiply and output states and waits there for output ready.
// Reset clears all targets, current values, the enable flag and the sequencer,
// and loads the register defaults.
// ----------------------------------------------------------------------------
module multichannel_slew_limited_pwm_drive_unit #(
  parameter int MAX_CHANNELS = msp_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [msp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  msp_in_if.sink                            in_i,
  msp_out_if.source                         out_o
);
  import msp_pkg::*;

  localparam int NUM_CH = (MAX_CHANNELS < CH_LIMIT) ? MAX_CHANNELS : CH_LIMIT;
  localparam int CH_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

  state_e state_q, state_d;
  ctrl_t  ctrl;

  logic [ACTIVE_W-1:0] active_q;
  logic [WRAP_W-1:0]   wrap_q;
  logic [MAG_W-1:0]    step_q;
  logic                enabled_q;

  logic signed [DRIVE_W-1:0] target_q  [NUM_CH];
  logic signed [DRIVE_W-1:0] current_q [NUM_CH];

  logic [CH_W-1:0]     idx_q;
  logic [ACTIVE_W-1:0] cnt_q;
  logic [MAG_W-1:0]    mag_q;
  logic                phase_q;

  logic                in_acc;
  logic                out_acc;
  cmd_e                cmd;
  logic [ACTIVE_W-1:0] tick_cnt;
  logic                last;
  logic                ch_ok;
  logic signed [DRIVE_W-1:0] clamped;

  logic signed [DRIVE_W-1:0] slew_cur;
  logic [MAG_W-1:0]          slew_mag;
  logic                      slew_neg;
  logic [WRAP_W-1:0]         duty;

  assign in_acc   = in_i.valid & ctrl.in_ready;
  assign out_acc  = ctrl.out_valid & out_o.ready;
  assign cmd      = cmd_e'(in_i.cmd);
  assign tick_cnt = (active_q > ACTIVE_W'(NUM_CH)) ? ACTIVE_W'(NUM_CH) : active_q;
  assign last     = (ACTIVE_W'(idx_q) + ACTIVE_W'(1)) == cnt_q;
  assign ch_ok    = (ACTIVE_W'(in_i.channel) < ACTIVE_W'(NUM_CH));

  // Clamp the requested target to plus or minus full scale
  always_comb begin
    if (in_i.target_value > TARGET_W'(FULL_SCALE)) begin
      clamped = FULL_SCALE;
    end else if (in_i.target_value < TARGET_W'(NEG_FULL_SCALE)) begin
      clamped = NEG_FULL_SCALE;
    end else begin
      clamped = in_i.target_value[DRIVE_W-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RST;
      wrap_q   <= WRAP_RST;
      step_q   <= STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE_BRIDGES: active_q <= cfg_wdata_i[ACTIVE_W-1:0];
        CFG_PWM_WRAP:       wrap_q   <= cfg_wdata_i[WRAP_W-1:0];
        CFG_SLEW_STEP:      step_q   <= cfg_wdata_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_TICK && tick_cnt != '0) begin
          state_d = ST_SLEW;
        end
      end
      ST_SLEW: state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          state_d = last ? ST_IDLE : ST_SLEW;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE: ctrl.in_ready  = 1'b1;
      ST_SLEW: ctrl.slew_en   = 1'b1;
      ST_MUL:  ctrl.mul_en    = 1'b1;
      ST_OUT:  ctrl.out_valid = 1'b1;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Channel walk counter and tick length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else if (in_acc && cmd == CMD_TICK) begin
      idx_q <= '0;
      cnt_q <= tick_cnt;
    end else if (out_acc && !last) begin
      idx_q <= idx_q + CH_W'(1);
    end
  end

  // Enable flag and target store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        target_q[i] <= '0;
      end
    end else if (in_acc) begin
      unique case (cmd)
        CMD_SET_TARGET: begin
          if (enabled_q && ch_ok) begin
            target_q[in_i.channel[CH_W-1:0]] <= clamped;
          end
        end
        CMD_SET_ENABLE: begin
          enabled_q <= in_i.enable_value;
          for (int i = 0; i < NUM_CH; i++) begin
            target_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  msp_slew_unit u_slew (
    .cur_i    (current_q[idx_q]),
    .target_i (target_q[idx_q]),
    .step_i   (step_q),
    .cur_o    (slew_cur),
    .mag_o    (slew_mag),
    .neg_o    (slew_neg)
  );

  // Write back the slewed value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        current_q[i] <= '0;
      end
    end else if (ctrl.slew_en) begin
      current_q[idx_q] <= slew_cur;
    end
  end

  // Hold sign and magnitude for the multiplier and output
  always_ff @(posedge clk_i) begin
    if (ctrl.slew_en) begin
      mag_q   <= slew_mag;
      phase_q <= slew_neg;
    end
  end

  msp_duty_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .wrap_i (wrap_q),
    .mag_i  (mag_q),
    .duty_o (duty)
  );

  // Drive the ports
  assign in_i.ready        = ctrl.in_ready;
  assign out_o.valid       = ctrl.out_valid;
  assign out_o.out_channel = CHANNEL_W'(idx_q);
  assign out_o.phase       = phase_q;
  assign out_o.duty_level  = duty;
  assign out_o.driver_off  = ~enabled_q;
  assign out_o.last        = last;

endmodule

// File: bench/multichannel_slew_limited_pwm_drive_unit_tb.sv
// ----------------------------------------------------------------------------
// multichannel_slew_limited_pwm_drive_unit_tb: self-checking bench
// Drives command transactions into the slew-limited PWM drive unit, keeps
// its own copy of targets, current values and registers, and compares every
// drive transaction on the result channel with the predicted one. Directed
// tests cover register defaults, disabled behavior, target clamping, zero
// step and the unused command. A random sweep then runs over several
// register settings with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module multichannel_slew_limited_pwm_drive_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  localparam int MAX_CH        = MAX_CHANNELS_DEF;
  localparam int SETTLE_CYCLES = 3 * MAX_CH + 8;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHANNEL_W-1:0] ch;
    logic                 phase;
    logic [WRAP_W-1:0]    duty;
    logic                 drv_off;
    logic                 last;
  } drive_rec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  msp_in_if  cmd_if ();
  msp_out_if drive_if ();

  multichannel_slew_limited_pwm_drive_unit #(
    .MAX_CHANNELS (MAX_CH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (cmd_if),
    .out_o       (drive_if)
  );

  // Shadow state of the drive unit
  logic signed [DRIVE_W-1:0] target_mem [MAX_CH];
  logic signed [DRIVE_W-1:0] drive_mem  [MAX_CH];
  logic                      enabled;
  logic [ACTIVE_W-1:0]       active_cnt;
  logic [WRAP_W-1:0]         wrap_val;
  logic [MAG_W-1:0]          step_val;

  drive_rec_t drive_q [$];
  int         fail_count = 0;
  int         idle_cycles = 0;
  bit         quiet_tx = 1'b0;
  bit         quiet_rx = 1'b0;
  int         stall_left = 0;

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Clamp, store or slew, and queue the drive transactions a command causes
  function automatic void predict_drive(logic [CMD_W-1:0] op, logic [CHANNEL_W-1:0] ch,
                                        logic signed [TARGET_W-1:0] tv, logic ev);
    int         n;
    int         cur;
    int         err;
    int         mag;
    int         tgt;
    logic [31:0] prod;
    drive_rec_t rec;
    case (op)
      CMD_SET_TARGET: begin
        if (enabled && int'(ch) < MAX_CH) begin
          tgt = tv;
          if (tgt > 32767) tgt = 32767;
          if (tgt < -32767) tgt = -32767;
          target_mem[ch] = DRIVE_W'(tgt);
        end
      end
      CMD_SET_ENABLE: begin
        for (int i = 0; i < MAX_CH; i++) target_mem[i] = '0;
        enabled = ev;
      end
      CMD_TICK: begin
        n = active_cnt;
        if (n > MAX_CH) n = MAX_CH;
        if (n > 8) n = 8;
        for (int i = 0; i < n; i++) begin
          cur = drive_mem[i];
          tgt = target_mem[i];
          err = tgt - cur;
          mag = (err < 0) ? -err : err;
          if (mag < int'(step_val)) cur = tgt;
          else if (err > 0) cur = cur + int'(step_val);
          else if (err < 0) cur = cur - int'(step_val);
          drive_mem[i] = DRIVE_W'(cur);
          mag = (cur < 0) ? -cur : cur;
          prod = 32'(wrap_val) * 32'(mag);
          rec.ch      = CHANNEL_W'(i);
          rec.phase   = (cur < 0);
          rec.duty    = prod[30:15];
          rec.drv_off = ~enabled;
          rec.last    = (i == n - 1);
          drive_q.push_back(rec);
        end
      end
      default: ;
    endcase
  endfunction

  // Check drive transactions, track register writes, predict on accepted commands
  always @(posedge clk_i) begin : drive_monitor
    drive_rec_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CH; i++) begin
        target_mem[i] = '0;
        drive_mem[i]  = '0;
      end
      enabled    = 1'b0;
      active_cnt = ACTIVE_RST;
      wrap_val   = WRAP_RST;
      step_val   = STEP_RST;
      drive_q.delete();
    end else begin
      if (drive_if.valid && drive_if.ready) begin
        if (drive_q.size() == 0) begin
          $error("unexpected drive transaction on channel %0d", drive_if.out_channel);
          fail_count++;
        end else begin
          want = drive_q.pop_front();
          if (drive_if.out_channel !== want.ch) begin
            $error("out_channel: expected %0d, actual %0d", want.ch, drive_if.out_channel);
            fail_count++;
          end
          if (drive_if.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, drive_if.phase);
            fail_count++;
          end
          if (drive_if.duty_level !== want.duty) begin
            $error("duty_level: expected %0d, actual %0d", want.duty, drive_if.duty_level);
            fail_count++;
          end
          if (drive_if.driver_off !== want.drv_off) begin
            $error("driver_off: expected %0d, actual %0d", want.drv_off,
                   drive_if.driver_off);
            fail_count++;
          end
          if (drive_if.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, drive_if.last);
            fail_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACTIVE_BRIDGES: active_cnt = cfg_wdata_i[ACTIVE_W-1:0];
          CFG_PWM_WRAP:       wrap_val   = cfg_wdata_i[WRAP_W-1:0];
          CFG_SLEW_STEP:      step_val   = cfg_wdata_i[MAG_W-1:0];
          default: ;
        endcase
      end
      if (cmd_if.valid && cmd_if.ready)
        predict_drive(cmd_if.cmd, cmd_if.channel, cmd_if.target_value, cmd_if.enable_value);
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      drive_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet_rx && $urandom_range(0, 3) == 0) begin
      drive_if.ready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      drive_if.ready <= 1'b1;
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (drive_if.valid && drive_if.ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one command transaction and hold it until accepted
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [CHANNEL_W-1:0] ch = '0,
                          input logic signed [TARGET_W-1:0] tv = '0, input logic ev = 1'b0);
    int gap;
    gap = quiet_tx ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.cmd          <= op;
    cmd_if.channel      <= ch;
    cmd_if.target_value <= tv;
    cmd_if.enable_value <= ev;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  // Drop valid, wait for every pending drive transaction, then let the unit settle
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] act, input logic [CFG_DATA_W-1:0] wrap,
                          input logic [CFG_DATA_W-1:0] step);
    write_reg(CFG_ACTIVE_BRIDGES, act);
    write_reg(CFG_PWM_WRAP, wrap);
    write_reg(CFG_SLEW_STEP, step);
  endtask

  // Mix of raw 17-bit values, range edges and in-range values
  function automatic logic signed [TARGET_W-1:0] pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return TARGET_W'($urandom);
    if (r < 6) begin
      case ($urandom_range(0, 7))
        0: return 17'sd32767;
        1: return -17'sd32767;
        2: return 17'sd32768;
        3: return -17'sd32768;
        4: return 17'sd65535;
        5: return 17'sh10000;
        6: return 17'sd1;
        default: return -17'sd1;
      endcase
    end
    return TARGET_W'($urandom_range(0, 65534)) - 17'sd32767;
  endfunction

  task automatic send_random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      send_cmd(CMD_SET_TARGET, CHANNEL_W'($urandom_range(0, 7)), pick_target(),
               1'($urandom_range(0, 1)));
    else if (r < 85)
      send_cmd(CMD_TICK, CHANNEL_W'($urandom_range(0, 7)), TARGET_W'($urandom),
               1'($urandom_range(0, 1)));
    else if (r < 95)
      send_cmd(CMD_SET_ENABLE, CHANNEL_W'($urandom_range(0, 7)), TARGET_W'($urandom),
               ($urandom_range(0, 5) != 0));
    else
      send_cmd(CMD_UNUSED, CHANNEL_W'($urandom_range(0, 7)), TARGET_W'($urandom),
               1'($urandom_range(0, 1)));
  endtask

  // Reset register values: no channel active, then default wrap and step
  task automatic test_reset_defaults();
    send_cmd(CMD_TICK);
    send_cmd(CMD_TICK);
    wait_idle();
    write_reg(CFG_ACTIVE_BRIDGES, 16'd8);
    // targets are ignored while disabled, ticks still report
    send_cmd(CMD_SET_TARGET, 3'd3, 17'sd1000);
    send_cmd(CMD_TICK);
    send_cmd(CMD_SET_ENABLE, 3'd0, 17'sd0, 1'b1);
    send_cmd(CMD_SET_TARGET, 3'd0, 17'sd20000);
    send_cmd(CMD_SET_TARGET, 3'd7, -17'sd5000);
    send_cmd(CMD_TICK);
    send_cmd(CMD_TICK);
  endtask

  // Saturate out-of-range targets and slew with the largest step and wrap
  task automatic test_target_clamp();
    send_cmd(CMD_SET_TARGET, 3'd0, 17'sd65535);
    send_cmd(CMD_SET_TARGET, 3'd1, 17'sh10000);
    send_cmd(CMD_SET_TARGET, 3'd2, 17'sd32767);
    send_cmd(CMD_SET_TARGET, 3'd3, -17'sd32767);
    send_cmd(CMD_SET_TARGET, 3'd4, 17'sd32768);
    send_cmd(CMD_SET_TARGET, 3'd5, -17'sd32768);
    send_cmd(CMD_SET_TARGET, 3'd6, 17'sd1);
    send_cmd(CMD_SET_TARGET, 3'd7, -17'sd1);
    wait_idle();
    set_regs(16'd8, 16'd65535, 16'd32767);
    send_cmd(CMD_TICK);
    send_cmd(CMD_TICK);
  endtask

  // Zero step: hold every current value, zero error included
  task automatic test_zero_step();
    wait_idle();
    set_regs(16'd4, 16'd4999, 16'd0);
    send_cmd(CMD_TICK);
  endtask

  // Unused command, disable, and slewing toward zeroed targets with count above range
  task automatic test_disable_unused();
    send_cmd(CMD_UNUSED, 3'd5, 17'sd12345, 1'b1);
    send_cmd(CMD_SET_ENABLE, 3'd0, 17'sd0, 1'b0);
    wait_idle();
    set_regs(16'd15, 16'd4999, 16'd20000);
    send_cmd(CMD_TICK);
    send_cmd(CMD_TICK);
  endtask

  // Random commands over a sweep of register settings
  task automatic test_random_sweep();
    logic [CFG_DATA_W-1:0] act_set  [9] = '{16'd8, 16'd1, 16'd8, 16'd15, 16'd3,
                                            16'd0, 16'd5, 16'd8, 16'd2};
    logic [CFG_DATA_W-1:0] wrap_set [9] = '{16'd4999, 16'd0, 16'd65535, 16'd65535,
                                            16'd4999, 16'd1000, 16'd0, 16'd32768, 16'd7};
    logic [CFG_DATA_W-1:0] step_set [9] = '{16'd1638, 16'd1, 16'd32767, 16'd1,
                                            16'd0, 16'd500, 16'd16384, 16'd4000, 16'd100};
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      if (p == 8)
        set_regs(16'($urandom_range(0, 15)), 16'($urandom), 16'($urandom_range(0, 32767)));
      else
        set_regs(act_set[p], wrap_set[p], step_set[p]);
      quiet_tx = (p % 3 == 2);
      quiet_rx = (p % 4 == 3);
      send_cmd(CMD_SET_ENABLE, 3'd0, 17'sd0, 1'b1);
      for (int k = 0; k < 50; k++) begin
        // halfway through even passes, hold off until every pending drive transaction has drained
        if (k == 25 && p % 2 == 0) wait_idle();
        send_random_cmd();
      end
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  initial begin
    cmd_if.valid        = 1'b0;
    cmd_if.cmd          = CMD_SET_TARGET;
    cmd_if.channel      = '0;
    cmd_if.target_value = '0;
    cmd_if.enable_value = 1'b0;
    drive_if.ready      = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_ACTIVE_BRIDGES;
    cfg_wdata_i         = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_target_clamp();
    test_zero_step();
    test_disable_unused();
    test_random_sweep();

    wait_idle();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
